@@ design/ntm_pkg.sv @@
package ntm_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int STAMP_W    = 64;
  localparam int WORD_W     = 8;
  localparam int TRACK_W    = 8;
  localparam int GROUP_W    = 10;
  localparam int DIFF_W     = 39;
  localparam int TOL_W      = 20;
  localparam int TOTAL_W    = 32;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // search starts at five minutes in nanoseconds
  localparam logic [DIFF_W-1:0] START_DIFF = 39'd300000000000;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TRACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ALL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd3;

  // configuration reset values
  localparam logic [WORD_W-1:0]  RST_TARGET_WORD  = 8'd5;
  localparam logic [TRACK_W-1:0] RST_TARGET_TRACK = 8'd14;
  localparam logic [TOL_W-1:0]   RST_TOLERANCE    = 20'd200;

  // one stored trigger record
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [WORD_W-1:0]  word;
    logic [TRACK_W-1:0] track;
    logic [GROUP_W-1:0] group;
  } ntm_entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic issue;
    logic finish;
  } ntm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_end;
    logic pipe_empty;
    logic out_free;
  } ntm_status_t;

endpackage

@@ design/ntm_ctrl.sv @@
module ntm_ctrl
  import ntm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] operation,
  input  ntm_status_t     status,
  output ntm_cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } ntm_state_t;

  ntm_state_t state;
  ntm_state_t state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (operation == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (operation == OP_MATCH) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!status.issue_end) begin
          cmd.issue = 1'b1;
        end else if (status.pipe_empty) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/ntm_dpath.sv @@
module ntm_dpath
  import ntm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ntm_cmd_t              cmd,
  output ntm_status_t           status,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [STAMP_W-1:0]    stamp,
  input  logic [WORD_W-1:0]     trig_word,
  input  logic [TRACK_W-1:0]    trig_track,
  input  logic [GROUP_W-1:0]    group_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  matched,
  output logic [STAMP_W-1:0]    hit_stamp,
  output logic [STAMP_W-1:0]    best_trigger_stamp,
  output logic [TRACK_W-1:0]    best_track,
  output logic [GROUP_W-1:0]    best_group,
  output logic [DIFF_W-1:0]     best_difference,
  output logic [TOTAL_W-1:0]    match_total
);

  // configuration
  logic [WORD_W-1:0]  target_word;
  logic [TRACK_W-1:0] target_track;
  logic               match_all;
  logic [TOL_W-1:0]   tolerance_ns;

  // table
  ntm_entry_t         mem [TABLE_DEPTH];
  ntm_entry_t         rdata;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] idx;
  logic               table_full;

  // scan pipeline
  logic               rd_vld;
  logic               cmp_vld;
  logic               cmp_elig;
  logic [STAMP_W-1:0] cmp_diff;
  logic [STAMP_W-1:0] cmp_stamp;
  logic [TRACK_W-1:0] cmp_track;
  logic [GROUP_W-1:0] cmp_group;
  logic               elig;
  logic [STAMP_W-1:0] diff;

  // running best
  logic [STAMP_W-1:0] hit;
  logic [DIFF_W-1:0]  best;
  logic [STAMP_W-1:0] best_stamp;
  logic [TRACK_W-1:0] best_trk;
  logic [GROUP_W-1:0] best_grp;
  logic               better;

  // finish
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic               ok;

  assign table_full = (count >= COUNT_W'(TABLE_DEPTH));

  assign status.issue_end  = (idx == count);
  assign status.pipe_empty = !rd_vld && !cmp_vld;
  assign status.out_free   = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_word  <= RST_TARGET_WORD;
      target_track <= RST_TARGET_TRACK;
      match_all    <= 1'b0;
      tolerance_ns <= RST_TOLERANCE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TARGET_WORD:  target_word  <= cfg_data[WORD_W-1:0];
        CFG_TARGET_TRACK: target_track <= cfg_data[TRACK_W-1:0];
        CFG_MATCH_ALL:    match_all    <= cfg_data[0];
        CFG_TOLERANCE:    tolerance_ns <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !table_full) begin
      mem[count[ADDR_W-1:0]] <= '{stamp: stamp, word: trig_word,
                                 track: trig_track, group: group_number};
    end
    rdata <= mem[idx[ADDR_W-1:0]];
  end

  // fill count and scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.load && !table_full) begin
        count <= count + COUNT_W'(1);
      end
      if (cmd.start) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + COUNT_W'(1);
      end
    end
  end

  // eligibility and absolute difference
  always_comb begin
    elig = match_all || (rdata.word == target_word && rdata.track == target_track);
    diff = (hit > rdata.stamp) ? hit - rdata.stamp : rdata.stamp - hit;
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      cmp_vld <= rd_vld;
    end
  end

  // compare stage payload
  always_ff @(posedge clk) begin
    cmp_elig  <= elig;
    cmp_diff  <= diff;
    cmp_stamp <= rdata.stamp;
    cmp_track <= rdata.track;
    cmp_group <= rdata.group;
  end

  // strict less keeps the earliest record on ties
  assign better = cmp_vld && cmp_elig && (cmp_diff < {{(STAMP_W-DIFF_W){1'b0}}, best});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit        <= stamp;
      best       <= START_DIFF;
      best_stamp <= '0;
      best_trk   <= '0;
      best_grp   <= '0;
    end else if (better) begin
      best       <= cmp_diff[DIFF_W-1:0];
      best_stamp <= cmp_stamp;
      best_trk   <= cmp_track;
      best_grp   <= cmp_group;
    end
  end

  // acceptance and saturating counter
  always_comb begin
    ok = (best < {{(DIFF_W-TOL_W){1'b0}}, tolerance_ns});
    if (ok && (total != '1)) begin
      total_next = total + TOTAL_W'(1);
    end else begin
      total_next = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.finish) begin
      total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched            <= ok;
      hit_stamp          <= hit;
      best_trigger_stamp <= best_stamp;
      best_track         <= best_trk;
      best_group         <= best_grp;
      best_difference    <= best;
      match_total        <= total_next;
    end
  end

endmodule

@@ design/nearest_trigger_time_match.sv @@
// channel | signals                                   | handshake
// input   | operation stamp trig_word trig_track      | in_valid / in_ready
//         | group_number                              |
// output  | matched hit_stamp best_trigger_stamp      | out_valid / out_ready
//         | best_track best_group best_difference     |
//         | match_total                               |
// config  | cfg_index cfg_data                        | cfg_write_en, no wait
//
// clear and load complete while the block stays idle; a match scans the table
// through the single read port of the record memory, one entry per cycle.
// one transaction at a time: in_ready is high only while the block is idle.
// a finished result sits in the output register while the next transaction
// is accepted; a match waits at its end only if that register is still full.
// rst is synchronous and empties the table; no clearing pass is needed.
module nearest_trigger_time_match
  import ntm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [STAMP_W-1:0]    stamp,
  input  logic [WORD_W-1:0]     trig_word,
  input  logic [TRACK_W-1:0]    trig_track,
  input  logic [GROUP_W-1:0]    group_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  matched,
  output logic [STAMP_W-1:0]    hit_stamp,
  output logic [STAMP_W-1:0]    best_trigger_stamp,
  output logic [TRACK_W-1:0]    best_track,
  output logic [GROUP_W-1:0]    best_group,
  output logic [DIFF_W-1:0]     best_difference,
  output logic [TOTAL_W-1:0]    match_total,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ntm_cmd_t    cmd;
  ntm_status_t status;

  ntm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  ntm_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .stamp              (stamp),
    .trig_word          (trig_word),
    .trig_track         (trig_track),
    .group_number       (group_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .matched            (matched),
    .hit_stamp          (hit_stamp),
    .best_trigger_stamp (best_trigger_stamp),
    .best_track         (best_track),
    .best_group         (best_group),
    .best_difference    (best_difference),
    .match_total        (match_total)
  );

endmodule

@@ design/ntm_checker.sv @@
module ntm_checker
  import ntm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 matched,
  input logic [STAMP_W-1:0]   hit_stamp,
  input logic [STAMP_W-1:0]   best_trigger_stamp,
  input logic [TRACK_W-1:0]   best_track,
  input logic [GROUP_W-1:0]   best_group,
  input logic [DIFF_W-1:0]    best_difference,
  input logic [TOTAL_W-1:0]   match_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_stamp) && $stable(match_total))
    else $error("result changed while stalled");

  // the search never reports more than its starting difference
  a_diff_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_difference <= START_DIFF)
    else $error("best difference above start value");

  // no eligible record means an all-zero record and no match
  a_none_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_difference == START_DIFF |->
      best_trigger_stamp == '0 && best_track == '0 && best_group == '0 && !matched)
    else $error("empty search reported a record");

  // a match needs a difference within the largest tolerance
  a_match_tol: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> best_difference < DIFF_W'(1 << TOL_W) && match_total != '0)
    else $error("match outside tolerance range");

endmodule

bind nearest_trigger_time_match ntm_checker u_ntm_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .matched            (matched),
  .hit_stamp          (hit_stamp),
  .best_trigger_stamp (best_trigger_stamp),
  .best_track         (best_track),
  .best_group         (best_group),
  .best_difference    (best_difference),
  .match_total        (match_total)
);
